/* hdl/x86enc_pkg.sv */
`timescale 1ns / 1ps
// x86enc_pkg: opcode bytes, function codes and the single-pass encoder function
// for the instruction byte encoder. No dependencies.

package x86enc_pkg;

   localparam int MAX_BYTES = 10;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   localparam logic [7:0] REX_W      = 8'h48;
   localparam logic [7:0] REX_R      = 8'h04;
   localparam logic [7:0] REX_B      = 8'h01;
   localparam logic [7:0] OP_MOV_IMM = 8'hB8;
   localparam logic [7:0] OP_MOV     = 8'h89;
   localparam logic [7:0] OP_ADD     = 8'h01;
   localparam logic [7:0] OP_SUB     = 8'h29;
   localparam logic [7:0] OP_ESC     = 8'h0F;
   localparam logic [7:0] OP_IMUL    = 8'hAF;
   localparam logic [7:0] OP_CMP     = 8'h39;
   localparam logic [7:0] OP_JCC     = 8'h80;
   localparam logic [7:0] MODRM_REG  = 8'hC0;
   localparam logic [7:0] OP_RET     = 8'hC3;

   localparam logic [CNT_W-1:0] LEN_MOV_IMM64 = CNT_W'(10);
   localparam logic [CNT_W-1:0] LEN_MOV_IMM32 = CNT_W'(5);
   localparam logic [CNT_W-1:0] LEN_JCC       = CNT_W'(6);
   localparam logic [CNT_W-1:0] LEN_RET       = CNT_W'(1);
   localparam logic [CNT_W-1:0] LEN_REG_BASE  = CNT_W'(2);

   typedef enum logic [2:0] {
      FUNC_MOV_IMM = 3'd0,
      FUNC_MOV     = 3'd1,
      FUNC_ADD     = 3'd2,
      FUNC_SUB     = 3'd3,
      FUNC_IMUL    = 3'd4,
      FUNC_CMP     = 3'd5,
      FUNC_JCC     = 3'd6,
      FUNC_RET     = 3'd7
   } func_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          len;
   } enc_type;

   function automatic enc_type encode(input func_type    f,
                                      input logic [3:0]  d,
                                      input logic [3:0]  s,
                                      input logic [63:0] imm,
                                      input logic [3:0]  c,
                                      input logic [31:0] off,
                                      input logic        mode);
      enc_type          e;
      logic             two;
      logic [3:0]       rf;
      logic [3:0]       rm;
      logic [7:0]       op;
      logic [7:0]       modrm;
      logic [7:0]       rex;
      logic [CNT_W-1:0] p;
      e.bytes = '0;
      e.len   = LEN_RET;
      // imul swaps the roles of the two registers
      two   = (f == FUNC_IMUL);
      rf    = two ? d : s;
      rm    = two ? s : d;
      modrm = MODRM_REG | {2'b00, rf[2:0], 3'b000} | {5'b00000, rm[2:0]};
      rex   = REX_W | (rf[3] ? REX_R : 8'h00) | (rm[3] ? REX_B : 8'h00);
      p     = {{(CNT_W-1){1'b0}}, mode};
      unique case (f)
         FUNC_ADD:  op = OP_ADD;
         FUNC_SUB:  op = OP_SUB;
         FUNC_IMUL: op = OP_IMUL;
         FUNC_CMP:  op = OP_CMP;
         default:   op = OP_MOV;
      endcase
      unique case (f)
         FUNC_MOV_IMM: begin
            if (mode) begin
               e.bytes[0] = REX_W | (d[3] ? REX_B : 8'h00);
               e.bytes[1] = OP_MOV_IMM + {5'b00000, d[2:0]};
               for (int i = 0; i < 8; i++) e.bytes[2+i] = imm[8*i +: 8];
               e.len = LEN_MOV_IMM64;
            end else begin
               e.bytes[0] = OP_MOV_IMM + {5'b00000, d[2:0]};
               for (int i = 0; i < 4; i++) e.bytes[1+i] = imm[8*i +: 8];
               e.len = LEN_MOV_IMM32;
            end
         end
         FUNC_JCC: begin
            e.bytes[0] = OP_ESC;
            e.bytes[1] = OP_JCC + {4'b0000, c};
            for (int i = 0; i < 4; i++) e.bytes[2+i] = off[8*i +: 8];
            e.len = LEN_JCC;
         end
         FUNC_RET: begin
            e.bytes[0] = OP_RET;
            e.len      = LEN_RET;
         end
         default: begin
            if (mode) e.bytes[0] = rex;
            if (two) begin
               e.bytes[p]               = OP_ESC;
               e.bytes[p + CNT_W'(1)]   = op;
               e.bytes[p + CNT_W'(2)]   = modrm;
            end else begin
               e.bytes[p]               = op;
               e.bytes[p + CNT_W'(1)]   = modrm;
            end
            e.len = LEN_REG_BASE + {{(CNT_W-1){1'b0}}, two} + p;
         end
      endcase
      return e;
   endfunction

endpackage

/* hdl/x86_instruction_byte_encoder.sv */
`timescale 1ns / 1ps
// x86_instruction_byte_encoder: turns one instruction request into its machine
// code bytes, one byte per response beat. Depends on x86enc_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | func, dst_reg, src_reg, immediate,
//          |           |                    | condition, jump_offset
//  rsp     | out       | rsp_valid/stall    | code_byte, last
//  csr     | in        | csr_valid/ready    | target_mode (reset 1)
//
// an instruction of n bytes (1 to 10) occupies the byte buffer until its last
// byte leaves, one byte per cycle unless rsp_stall holds it; the next request is taken
// in the cycle its last byte leaves, so instructions run back to back.
// reset is synchronous: buffer empty, target_mode 64-bit.
// rsp_stall holds the head byte and, through req_stall, the next request.

module x86_instruction_byte_encoder
   import x86enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_dst_reg,
   input  logic [3:0]  req_src_reg,
   input  logic [63:0] req_immediate,
   input  logic [3:0]  req_condition,
   input  logic signed [31:0] req_jump_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_target_mode
);

   logic [MAX_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      mode_ff, mode_in;
   logic                      req_beat;
   logic                      rsp_beat;
   enc_type                   enc;

   assign csr_ready = 1'b1;

   assign rsp_valid     = (count_ff != '0);
   assign rsp_code_byte = bytes_ff[0];
   assign rsp_last      = (count_ff == CNT_W'(1));
   assign rsp_beat      = rsp_valid && !rsp_stall;

   // take a new request when the buffer is empty or its last byte leaves now
   assign req_stall = rsp_valid && !(rsp_last && !rsp_stall);
   assign req_beat  = req_valid && !req_stall;

   always_comb begin
      enc = encode(func_type'(req_func), req_dst_reg, req_src_reg, req_immediate,
                   req_condition, req_jump_offset, mode_ff);
   end

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      mode_in  = mode_ff;
      if (csr_valid && csr_ready) mode_in = csr_target_mode;
      if (req_beat) begin
         bytes_in = enc.bytes;
         count_in = enc.len;
      end else if (rsp_beat) begin
         for (int i = 0; i < MAX_BYTES - 1; i++) bytes_in[i] = bytes_ff[i+1];
         bytes_in[MAX_BYTES-1] = 8'h00;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= 1'b1;
      end else begin
         count_ff <= count_in;
         mode_ff  <= mode_in;
      end
      bytes_ff <= bytes_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BYTES))
      else $error("byte count beyond buffer depth");

   a_req_then_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_valid)
      else $error("accepted request produced no byte");

   a_not_last_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_last) |=> rsp_valid)
      else $error("instruction ended without last byte");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> (count_ff == '0 || (rsp_last && rsp_beat)))
      else $error("request accepted over pending bytes");

endmodule

/* bench/x86_instruction_byte_encoder_tb.sv */
`timescale 1ns / 1ps
// x86_instruction_byte_encoder_tb: self-checking bench for the instruction byte encoder,
// predicting every code byte per request in both encoding modes. Depends on x86enc_pkg
// and x86_instruction_byte_encoder.

module x86_instruction_byte_encoder_tb;
   import x86enc_pkg::*;

   typedef struct {
      func_type           func;
      logic [3:0]         dst;
      logic [3:0]         src;
      logic [63:0]        imm;
      logic [3:0]         cond;
      logic signed [31:0] off;
   } instr_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } code_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = FUNC_RET;
   logic [3:0]  req_dst_reg = '0;
   logic [3:0]  req_src_reg = '0;
   logic [63:0] req_immediate = '0;
   logic [3:0]  req_condition = '0;
   logic signed [31:0] req_jump_offset = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_code_byte;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_target_mode = 1'b1;

   instr_type     pending_instrs[$];
   code_beat_type expected_bytes[$];
   instr_type     cur_instr;
   logic          enc_mode = 1'b1;
   int            send_idle_pct = 16;
   int            recv_idle_pct = 68;
   int            err_count = 0;
   int            instrs_sent = 0;
   int            bytes_seen = 0;

   x86_instruction_byte_encoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_dst_reg     (req_dst_reg),
      .req_src_reg     (req_src_reg),
      .req_immediate   (req_immediate),
      .req_condition   (req_condition),
      .req_jump_offset (req_jump_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_target_mode (csr_target_mode)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // machine code for one instruction under the current mode
   task automatic push_encoding(input instr_type it);
      logic [7:0] bytes[$];
      logic [3:0] reg_fld;
      logic [3:0] rm_fld;
      logic [7:0] op;
      logic [7:0] rex;
      bit         esc;
      case (it.func)
         FUNC_MOV_IMM: begin
            if (enc_mode) begin
               bytes.push_back(it.dst[3] ? (REX_W | REX_B) : REX_W);
               bytes.push_back(OP_MOV_IMM + {5'b00000, it.dst[2:0]});
               for (int i = 0; i < 8; i++) bytes.push_back(it.imm[8*i +: 8]);
            end else begin
               bytes.push_back(OP_MOV_IMM + {5'b00000, it.dst[2:0]});
               for (int i = 0; i < 4; i++) bytes.push_back(it.imm[8*i +: 8]);
            end
         end
         FUNC_JCC: begin
            bytes.push_back(OP_ESC);
            bytes.push_back(OP_JCC + {4'b0000, it.cond});
            for (int i = 0; i < 4; i++) bytes.push_back(it.off[8*i +: 8]);
         end
         FUNC_RET: bytes.push_back(OP_RET);
         default: begin
            // imul puts the destination in modrm.reg, the others the source
            esc     = (it.func == FUNC_IMUL);
            reg_fld = esc ? it.dst : it.src;
            rm_fld  = esc ? it.src : it.dst;
            case (it.func)
               FUNC_ADD:  op = OP_ADD;
               FUNC_SUB:  op = OP_SUB;
               FUNC_IMUL: op = OP_IMUL;
               FUNC_CMP:  op = OP_CMP;
               default:   op = OP_MOV;
            endcase
            rex = REX_W;
            if (reg_fld[3]) rex = rex | REX_R;
            if (rm_fld[3]) rex = rex | REX_B;
            if (enc_mode) bytes.push_back(rex);
            if (esc) bytes.push_back(OP_ESC);
            bytes.push_back(op);
            bytes.push_back(MODRM_REG | {2'b00, reg_fld[2:0], 3'b000} | {5'b00000, rm_fld[2:0]});
         end
      endcase
      foreach (bytes[k]) expected_bytes.push_back('{bytes[k], k == bytes.size() - 1});
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            push_encoding(cur_instr);
            instrs_sent++;
         end
         if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_instr = pending_instrs.pop_front();
            req_valid       <= 1'b1;
            req_func        <= cur_instr.func;
            req_dst_reg     <= cur_instr.dst;
            req_src_reg     <= cur_instr.src;
            req_immediate   <= cur_instr.imm;
            req_condition   <= cur_instr.cond;
            req_jump_offset <= cur_instr.off;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      code_beat_type exp_beat;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected beat, got code %02h last %0b",
                        $time, rsp_code_byte, rsp_last);
               err_count++;
            end else begin
               exp_beat = expected_bytes.pop_front();
               if (rsp_code_byte !== exp_beat.code) begin
                  $display("%0t: byte %0d code mismatch, expected %02h got %02h",
                           $time, bytes_seen, exp_beat.code, rsp_code_byte);
                  err_count++;
               end
               if (rsp_last !== exp_beat.last) begin
                  $display("%0t: byte %0d last mismatch, expected %0b got %0b",
                           $time, bytes_seen, exp_beat.last, rsp_last);
                  err_count++;
               end
            end
            bytes_seen++;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic add_instr(input func_type f, input logic [3:0] d, input logic [3:0] s,
                            input logic [63:0] imm, input logic [3:0] c,
                            input logic signed [31:0] off);
      instr_type it;
      it = '{f, d, s, imm, c, off};
      pending_instrs.push_back(it);
   endtask

   function automatic logic [3:0] pick_reg();
      logic [3:0] edge_regs[4];
      edge_regs = '{4'd0, 4'd7, 4'd8, 4'd15};
      if ($urandom_range(3) == 0) return edge_regs[$urandom_range(3)];
      return 4'($urandom);
   endfunction

   task automatic add_random(input int n);
      logic [63:0] imm;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(7))
            0:       imm = '0;
            1:       imm = '1;
            default: imm = {$urandom, $urandom};
         endcase
         add_instr(func_type'($urandom_range(7)), pick_reg(), pick_reg(), imm,
                   4'($urandom), $urandom);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_instrs.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic v);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_target_mode <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      enc_mode = v;
   endtask

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 64-bit mode out of reset: rex bits, immediate and offset extremes
      add_instr(FUNC_MOV_IMM, 4'd0, 4'd0, 64'h0, 4'd0, 0);
      add_instr(FUNC_MOV_IMM, 4'd15, 4'd3, '1, 4'd5, -1);
      add_instr(FUNC_MOV_IMM, 4'd8, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd0, 0);
      add_instr(FUNC_MOV, 4'd0, 4'd15, '1, 4'd15, -1);
      add_instr(FUNC_ADD, 4'd15, 4'd0, '0, 4'd0, 0);
      add_instr(FUNC_SUB, 4'd8, 4'd8, '0, 4'd0, 0);
      add_instr(FUNC_IMUL, 4'd15, 4'd7, '0, 4'd0, 0);
      add_instr(FUNC_IMUL, 4'd7, 4'd15, '0, 4'd0, 0);
      add_instr(FUNC_CMP, 4'd15, 4'd15, '0, 4'd0, 0);
      add_instr(FUNC_JCC, 4'd0, 4'd0, '0, 4'd0, 32'sh8000_0000);
      add_instr(FUNC_JCC, 4'd15, 4'd15, '1, 4'd15, 32'sh7FFF_FFFF);
      add_instr(FUNC_JCC, 4'd3, 4'd9, '0, 4'd4, -1);
      add_instr(FUNC_RET, 4'd15, 4'd15, '1, 4'd15, -1);
      wait_idle();

      // 32-bit mode: registers masked, upper immediate dropped
      csr_write(1'b0);
      add_instr(FUNC_MOV_IMM, 4'd15, 4'd0, 64'hFFFF_FFFF_0000_0000, 4'd0, 0);
      add_instr(FUNC_MOV_IMM, 4'd9, 4'd0, '1, 4'd0, 0);
      add_instr(FUNC_MOV_IMM, 4'd0, 4'd0, 64'h0000_0000_89AB_CDEF, 4'd0, 0);
      add_instr(FUNC_MOV, 4'd15, 4'd15, '0, 4'd0, 0);
      add_instr(FUNC_ADD, 4'd8, 4'd1, '0, 4'd0, 0);
      add_instr(FUNC_SUB, 4'd2, 4'd12, '0, 4'd0, 0);
      add_instr(FUNC_IMUL, 4'd15, 4'd8, '0, 4'd0, 0);
      add_instr(FUNC_CMP, 4'd0, 4'd15, '0, 4'd0, 0);
      add_instr(FUNC_JCC, 4'd15, 4'd15, '1, 4'd15, 32'sh8000_0000);
      add_instr(FUNC_RET, 4'd0, 4'd0, '0, 4'd0, 0);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 16; recv_idle_pct = 68; end
            1: begin send_idle_pct = 68; recv_idle_pct = 16; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         csr_write((ph % 2) == 0);
         add_random(31);
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
         err_count++;
      end
      $display("run covered %0d instructions, %0d code bytes, both encoding modes",
               instrs_sent, bytes_seen);
      $display("three stall patterns, %0d mismatches", err_count);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/x86enc_pkg.sv
hdl/x86_instruction_byte_encoder.sv
bench/x86_instruction_byte_encoder_tb.sv
